>>> hdl/erd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package erd_pkg;

   // Configuration register indexes.
   localparam logic CSR_ESCAPE_CODE = 1'b0;
   localparam logic CSR_FILL_VALUE  = 1'b1;

   // Command codes that follow an escape byte and need special handling.
   localparam logic [7:0] CMD_SHORT = 8'd0;
   localparam logic [7:0] CMD_LONG  = 8'd1;
   localparam logic [7:0] CMD_FILL  = 8'd2;

   // Depth of the queue between the parser and the run stage.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One parsed command handed from the parser to the run stage.
   typedef struct packed {
      logic        has_run;    // a run of count copies of value
      logic        is_end;     // end-of-stream code
      logic        last_byte;  // request carried the last-byte mark
      logic [7:0]  value;
      logic [16:0] count;      // up to 65536
   } cmd_type;

endpackage

`default_nettype wire

>>> hdl/erd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module erd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [7:0]       csr_wdata,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             req_tlast,
   output      logic             push_valid,
   input  wire logic             push_ready,
   output      erd_pkg::cmd_type push_data
);

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_ESC   = 5'b00010,
      PH_CODE  = 5'b00100,
      PH_HIGH  = 5'b01000,
      PH_VALUE = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  high_ff, high_in;
   logic [16:0] pending_ff, pending_in;
   logic [7:0]  escape_ff, fill_ff;
   logic        accept;
   logic [7:0]  b;
   erd_pkg::cmd_type cmd;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 8'd0;
         fill_ff   <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            erd_pkg::CSR_ESCAPE_CODE: escape_ff <= csr_wdata;
            erd_pkg::CSR_FILL_VALUE:  fill_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      code_in       = code_ff;
      high_in       = high_ff;
      pending_in    = pending_ff;
      cmd.has_run   = 1'b0;
      cmd.is_end    = 1'b0;
      cmd.last_byte = req_tlast;
      cmd.value     = 8'd0;
      cmd.count     = 17'd0;
      case (phase_ff)
         PH_IDLE: begin
            if (b != escape_ff) begin
               cmd.has_run = 1'b1;
               cmd.value   = b;
               cmd.count   = 17'd1;
            end else begin
               phase_in = PH_ESC;
            end
         end
         PH_ESC: begin
            if (b == escape_ff) begin
               cmd.has_run = 1'b1;
               cmd.value   = b;
               cmd.count   = 17'd1;
               phase_in    = PH_IDLE;
            end else begin
               code_in  = b;
               phase_in = PH_CODE;
            end
         end
         PH_CODE: begin
            if (code_ff == erd_pkg::CMD_FILL && b == 8'd0) begin
               cmd.is_end = 1'b1;
               phase_in   = PH_IDLE;
            end else if (code_ff == erd_pkg::CMD_LONG || code_ff == erd_pkg::CMD_FILL) begin
               high_in  = b;
               phase_in = PH_HIGH;
            end else if (code_ff == erd_pkg::CMD_SHORT) begin
               pending_in = 17'(b) + 17'd1;
               phase_in   = PH_VALUE;
            end else begin
               // Short repeat: the code itself holds the count less one.
               cmd.has_run = 1'b1;
               cmd.value   = b;
               cmd.count   = 17'(code_ff) + 17'd1;
               phase_in    = PH_IDLE;
            end
         end
         PH_HIGH: begin
            if (code_ff == erd_pkg::CMD_FILL) begin
               cmd.has_run = 1'b1;
               cmd.value   = fill_ff;
               cmd.count   = 17'({high_ff, b}) + 17'd1;
               phase_in    = PH_IDLE;
            end else begin
               pending_in = 17'({high_ff, b}) + 17'd1;
               phase_in   = PH_VALUE;
            end
         end
         PH_VALUE: begin
            cmd.has_run = 1'b1;
            cmd.value   = b;
            cmd.count   = pending_ff;
            phase_in    = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // A non-run byte other than the end code is only forwarded when it carries
   // the last mark, since the run stage may then have to report truncation.
   assign push_valid = accept && (cmd.has_run || cmd.is_end || cmd.last_byte);
   assign push_data  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         code_ff    <= 8'd0;
         high_ff    <= 8'd0;
         pending_ff <= 17'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         code_ff    <= code_in;
         high_ff    <= high_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/erd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module erd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output      logic             push_ready,
   input  wire erd_pkg::cmd_type push_data,
   output      logic             pop_valid,
   input  wire logic             pop_ready,
   output      erd_pkg::cmd_type pop_data
);

   erd_pkg::cmd_type                entry_ff [erd_pkg::QUEUE_DEPTH];
   logic [erd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [erd_pkg::QUEUE_CNT_W-1:0] count_ff;
   logic                            do_push, do_pop;

   assign push_ready = count_ff != erd_pkg::QUEUE_CNT_W'(erd_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == erd_pkg::QUEUE_DEPTH - 1) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == erd_pkg::QUEUE_DEPTH - 1) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hdl/erd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module erd_back #(
   parameter int SCREEN_BYTES = 32000
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             pop_valid,
   output      logic             pop_ready,
   input  wire erd_pkg::cmd_type pop_data,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      logic [39:0]      rsp_tdata,
   output      logic             rsp_tlast,
   output      logic [0:0]       rsp_tuser
);

   localparam logic [14:0] SCREEN_LEN = 15'(SCREEN_BYTES);

   logic [14:0] wi_ff, wi_in;
   logic        done_ff, done_in;
   logic        out_valid_ff;
   logic [7:0]  value_ff;
   logic [14:0] length_ff, start_ff;
   logic        finished_ff, truncated_ff;
   logic [14:0] room, len;
   logic [15:0] wi_sum;
   logic        take, emit;

   assign pop_ready = !out_valid_ff || rsp_tready;
   assign take      = pop_valid && pop_ready;
   // Once the stream is done every further command is dropped.
   assign emit      = take && !done_ff;

   always_comb begin
      room = SCREEN_LEN - wi_ff;
      if (!pop_data.has_run) begin
         len = 15'd0;
      end else if (pop_data.count < 17'(room)) begin
         len = pop_data.count[14:0];
      end else begin
         len = room;
      end
      wi_sum  = 16'(wi_ff) + 16'(len);
      wi_in   = wi_sum[14:0];
      done_in = pop_data.is_end || (wi_sum >= 16'(SCREEN_LEN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff        <= 15'd0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            wi_ff   <= wi_in;
            done_ff <= done_in;
         end
         if (pop_ready) begin
            out_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         value_ff     <= pop_data.value;
         length_ff    <= len;
         start_ff     <= wi_ff;
         finished_ff  <= done_in;
         truncated_ff <= pop_data.last_byte && !done_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {2'b00, start_ff, length_ff, value_ff};
   assign rsp_tlast    = finished_ff;
   assign rsp_tuser[0] = truncated_ff;

endmodule

`default_nettype wire

>>> hdl/escape_rle_run_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Escape-byte run-length decoder for a packed screen stream.
// Requests arrive on the req_ channel, one packed byte each; req_tlast marks
// the last byte of available input. Each request yields zero or one run on the
// rsp_ channel: value, clipped length and start index in rsp_tdata, rsp_tlast
// set when the screen is full or the end code was seen, rsp_tuser set when
// input ended before the stream finished (a zero-length status item if that
// byte made no run). After the stream is done, requests are taken and dropped.
// The csr_ port writes the escape code (index 0) and fill value (index 1); the
// user must do so only while the block is idle; the block does not enforce it.
// A parser accepts one request per cycle while the queue has room and hands
// parsed commands through a two-entry queue to the run stage, which clips
// against the write index and holds the result in an output register.
// Sustained throughput is one request per cycle while rsp_tready is high.
// When rsp_tready is low the output register and queue fill, and req_tready
// drops once the queue is full. Reset clears the parse state, the write index,
// the done state and both configuration registers.

module escape_rle_run_decoder #(
   parameter int SCREEN_BYTES = 32000
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // packed_byte
   input  wire logic        req_tlast,   // last_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // run_value, run_length, run_start, zero pad
   output      logic        rsp_tlast,   // finished
   output      logic [0:0]  rsp_tuser    // truncated
);

   logic             push_valid, push_ready, pop_valid, pop_ready;
   erd_pkg::cmd_type push_data, pop_data;

   erd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   erd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   erd_back #(
      .SCREEN_BYTES (SCREEN_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
